FILE: sv/sfae_pkg.sv
// ----------------------------------------------------------------------------
// sfae_pkg
// Shared types and constants of the short-form ALU execute unit.
// ----------------------------------------------------------------------------
package sfae_pkg;

    localparam int NUM_REGS    = 16;
    localparam int IDX_W       = 4;
    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 48;

    localparam logic [IDX_W-1:0] D15_INDEX = 4'd15;

    typedef enum logic [3:0] {
        OP_ADD        = 4'd0,
        OP_ADD_FROM15 = 4'd1,
        OP_ADD_TO15   = 4'd2,
        OP_ADDR_ADD   = 4'd3,
        OP_CADD       = 4'd4,
        OP_CADDN      = 4'd5,
        OP_CMOV       = 4'd6,
        OP_CMOVN      = 4'd7,
        OP_EQ         = 4'd8,
        OP_LT         = 4'd9,
        OP_MOV        = 4'd10,
        OP_MOV_ADDR   = 4'd11,
        OP_SH         = 4'd12,
        OP_SHA        = 4'd13
    } op_t;

    typedef struct packed {
        logic [3:0]        op;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] imm;
        logic              cnt_neg;
        logic [3:0]        sh_amt;
    } dec_t;

endpackage

FILE: sv/sfae_front.sv
// ----------------------------------------------------------------------------
// sfae_front
// Decode an incoming beat: extend the constant and form the shift count.
// ----------------------------------------------------------------------------
module sfae_front
(
    input  logic [3:0]          op,
    input  logic [3:0]          reg_index,
    input  logic [3:0]          const_field,
    output sfae_pkg::dec_t      dec
);
    import sfae_pkg::*;

    always_comb
    begin
        dec.op      = op;
        dec.idx     = reg_index;
        dec.cnt_neg = const_field[3];
        if (op == OP_MOV_ADDR)
        begin
            dec.imm = {{(DATA_W-4){1'b0}}, const_field};
        end
        else
        begin
            dec.imm = {{(DATA_W-4){const_field[3]}}, const_field};
        end
        if (const_field[3])
        begin
            dec.sh_amt = 4'(~const_field + 4'd1);
        end
        else
        begin
            dec.sh_amt = const_field;
        end
    end

endmodule

FILE: sv/sfae_queue.sv
// ----------------------------------------------------------------------------
// sfae_queue
// Short queue of decoded instructions between decode and execute.
// ----------------------------------------------------------------------------
module sfae_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  sfae_pkg::dec_t      push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output sfae_pkg::dec_t      pop_data
);
    import sfae_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    dec_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/sfae_back.sv
// ----------------------------------------------------------------------------
// sfae_back
// Execute stage: register files, flags, ALU and the output register.
// ----------------------------------------------------------------------------
module sfae_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  sfae_pkg::dec_t              in_data,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [sfae_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import sfae_pkg::*;

    logic [DATA_W-1:0] data_regs_reg [NUM_REGS];
    logic [DATA_W-1:0] addr_regs_reg [NUM_REGS];

    logic c_reg,   c_next;
    logic v_reg,   v_next;
    logic sv_reg,  sv_next;
    logic av_reg,  av_next;
    logic sav_reg, sav_next;

    logic                     out_valid_reg;
    logic [OUT_TDATA_W-1:0]   out_data_reg;

    logic              pop;
    logic              we;
    logic              isa;
    logic [IDX_W-1:0]  di;
    logic [DATA_W-1:0] val;

    logic [DATA_W-1:0] s, d15, areg, imm;
    logic [DATA_W-1:0] add_a, add_sum;
    logic              add_v;
    logic              c15;
    logic [DATA_W-1:0] tmax;
    logic [3:0]        amt;

    assign in_ready      = !out_valid_reg || m_axis_tready;
    assign pop           = in_valid && in_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        s       = data_regs_reg[in_data.idx];
        d15     = data_regs_reg[D15_INDEX];
        areg    = addr_regs_reg[in_data.idx];
        imm     = in_data.imm;
        amt     = in_data.sh_amt;
        c15     = (d15 != '0);
        add_a   = (in_data.op == OP_ADD_FROM15) ? d15 : s;
        add_sum = add_a + imm;
        add_v   = (add_sum[DATA_W-1] ^ add_a[DATA_W-1]) & ~(add_a[DATA_W-1] ^ imm[DATA_W-1]);
        tmax    = 32'h7FFF_FFFF >> amt;

        we       = 1'b0;
        isa      = 1'b0;
        di       = '0;
        val      = '0;
        c_next   = c_reg;
        v_next   = v_reg;
        sv_next  = sv_reg;
        av_next  = av_reg;
        sav_next = sav_reg;

        unique case (in_data.op)
            OP_ADD, OP_ADD_FROM15, OP_ADD_TO15, OP_CADD, OP_CADDN:
            begin
                if ((in_data.op != OP_CADD || c15) && (in_data.op != OP_CADDN || !c15))
                begin
                    we       = 1'b1;
                    di       = (in_data.op == OP_ADD_TO15) ? D15_INDEX : in_data.idx;
                    val      = add_sum;
                    v_next   = add_v;
                    sv_next  = sv_reg | add_v;
                    av_next  = add_sum[DATA_W-1] ^ add_sum[DATA_W-2];
                    sav_next = sav_reg | av_next;
                end
            end
            OP_ADDR_ADD:
            begin
                we  = 1'b1;
                isa = 1'b1;
                di  = in_data.idx;
                val = areg + imm;
            end
            OP_CMOV, OP_CMOVN:
            begin
                if ((in_data.op == OP_CMOV) == c15)
                begin
                    we  = 1'b1;
                    di  = in_data.idx;
                    val = imm;
                end
            end
            OP_EQ:
            begin
                we  = 1'b1;
                di  = D15_INDEX;
                val = {{(DATA_W-1){1'b0}}, (s == imm)};
            end
            OP_LT:
            begin
                we  = 1'b1;
                di  = D15_INDEX;
                val = {{(DATA_W-1){1'b0}}, ($signed(s) < $signed(imm))};
            end
            OP_MOV:
            begin
                we  = 1'b1;
                di  = in_data.idx;
                val = imm;
            end
            OP_MOV_ADDR:
            begin
                we  = 1'b1;
                isa = 1'b1;
                di  = in_data.idx;
                val = imm;
            end
            OP_SH:
            begin
                we  = 1'b1;
                di  = in_data.idx;
                val = in_data.cnt_neg ? (s >> amt) : (s << amt);
            end
            OP_SHA:
            begin
                we = 1'b1;
                di = in_data.idx;
                if (amt == '0)
                begin
                    c_next = 1'b0;
                    v_next = 1'b0;
                    val    = s;
                end
                else if (!in_data.cnt_neg)
                begin
                    c_next  = |(s & ~(32'hFFFF_FFFF >> amt));
                    v_next  = ($signed(s) > $signed(tmax)) || ($signed(s) < $signed(~tmax));
                    sv_next = sv_reg | v_next;
                    val     = s << amt;
                end
                else
                begin
                    c_next = |(s & ~(32'hFFFF_FFFF << amt));
                    v_next = 1'b0;
                    val    = DATA_W'($signed(s) >>> amt);
                end
                av_next  = val[DATA_W-1] ^ val[DATA_W-2];
                sav_next = sav_reg | av_next;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                data_regs_reg[i] <= '0;
                addr_regs_reg[i] <= '0;
            end
            c_reg         <= 1'b0;
            v_reg         <= 1'b0;
            sv_reg        <= 1'b0;
            av_reg        <= 1'b0;
            sav_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (we && isa)
                begin
                    addr_regs_reg[di] <= val;
                end
                if (we && !isa)
                begin
                    data_regs_reg[di] <= val;
                end
                c_reg         <= c_next;
                v_reg         <= v_next;
                sv_reg        <= sv_next;
                av_reg        <= av_next;
                sav_reg       <= sav_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= {5'b0, sav_next, av_next, sv_next, v_next, c_next,
                             val, di, isa, we};
        end
    end

endmodule

FILE: sv/short_form_alu_execute_unit.sv
// ----------------------------------------------------------------------------
// short_form_alu_execute_unit
// Short-form ALU execute unit with decode, instruction queue and execute.
// ----------------------------------------------------------------------------
// Takes one instruction beat per cycle and returns one result beat per cycle
// as long as the result side keeps tready high. Decode feeds a two-entry queue;
// the execute stage reads the register files, computes, writes back and
// updates the flags as it takes each instruction, so each instruction sees
// the results of the one before it. The queue entry and the output register
// lie between an input beat and its result beat.
module short_form_alu_execute_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // op[3:0], reg_index[7:4], const_field[11:8]
    input  logic [sfae_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // write_enable[0], dest_is_addr[1], dest_index[5:2], write_value[37:6],
    // flag_c[38], flag_v[39], flag_sv[40], flag_av[41], flag_sav[42]
    output logic [sfae_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
    import sfae_pkg::*;

    dec_t front_dec;
    dec_t back_dec;
    logic back_valid;
    logic back_ready;
    logic unused_pad;

    assign unused_pad = |s_axis_tdata[IN_TDATA_W-1:12];

    sfae_front u_front
    (
        .op          (s_axis_tdata[3:0]),
        .reg_index   (s_axis_tdata[7:4]),
        .const_field (s_axis_tdata[11:8]),
        .dec         (front_dec)
    );

    sfae_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (s_axis_tvalid),
        .push_ready (s_axis_tready),
        .push_data  (front_dec),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_dec)
    );

    sfae_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (back_valid),
        .in_ready      (back_ready),
        .in_data       (back_dec),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

FILE: bench/alu_result_checker.sv
// ----------------------------------------------------------------------------
// alu_result_checker
// Watches both stream channels of the short-form ALU execute unit, predicts
// the write-back and flags of every accepted instruction beat from its own
// copy of the register files and flags, and compares each result beat
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module alu_result_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [sfae_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [sfae_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output int                               errors,
    output int                               pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import sfae_pkg::*;

    localparam logic [DATA_W-1:0] MAX_POS     = 32'h7FFF_FFFF;
    localparam int                PRINT_LIMIT = 40;

    typedef struct packed {
        logic              sav;
        logic              av;
        logic              sv;
        logic              v;
        logic              c;
        logic [DATA_W-1:0] value;
        logic [IDX_W-1:0]  dest;
        logic              to_addr;
        logic              wr_en;
    } writeback_t;

    logic [DATA_W-1:0] data_file [NUM_REGS];
    logic [DATA_W-1:0] addr_file [NUM_REGS];
    logic              c_flag;
    logic              v_flag;
    logic              sv_flag;
    logic              av_flag;
    logic              sav_flag;
    writeback_t        writeback_q [$];
    int                fail_count = 0;

    assign errors = fail_count;

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        if (fail_count < PRINT_LIMIT)
            $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    function automatic logic [DATA_W-1:0] add_with_flags(input logic [DATA_W-1:0] a,
                                                         input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] sum;
        sum      = a + b;
        v_flag   = (sum[31] ^ a[31]) & ~(a[31] ^ b[31]);
        sv_flag  = sv_flag | v_flag;
        av_flag  = sum[31] ^ sum[30];
        sav_flag = sav_flag | av_flag;
        return sum;
    endfunction

    function automatic writeback_t execute_instr(input logic [3:0] op,
                                                 input logic [IDX_W-1:0] r,
                                                 input logic [3:0] kraw);
        writeback_t        res;
        logic [DATA_W-1:0] k;
        logic [DATA_W-1:0] s;
        logic [DATA_W-1:0] tmax;
        logic [DATA_W-1:0] msk;
        int                cnt;
        int                n;
        logic              d15_set;
        res     = '0;
        k       = {{(DATA_W-4){kraw[3]}}, kraw};
        cnt     = kraw[3] ? int'(kraw) - 16 : int'(kraw);
        s       = data_file[r];
        d15_set = data_file[D15_INDEX] != '0;
        case (op)
            OP_ADD:
            begin
                res.value = add_with_flags(s, k);
                res.wr_en = 1'b1;
                res.dest  = r;
            end
            OP_ADD_FROM15:
            begin
                res.value = add_with_flags(data_file[D15_INDEX], k);
                res.wr_en = 1'b1;
                res.dest  = r;
            end
            OP_ADD_TO15:
            begin
                res.value = add_with_flags(s, k);
                res.wr_en = 1'b1;
                res.dest  = D15_INDEX;
            end
            OP_ADDR_ADD:
            begin
                res.value   = addr_file[r] + k;
                res.wr_en   = 1'b1;
                res.to_addr = 1'b1;
                res.dest    = r;
            end
            OP_CADD, OP_CADDN:
            begin
                if ((op == OP_CADD) == d15_set)
                begin
                    res.value = add_with_flags(s, k);
                    res.wr_en = 1'b1;
                    res.dest  = r;
                end
            end
            OP_CMOV, OP_CMOVN:
            begin
                if ((op == OP_CMOV) == d15_set)
                begin
                    res.value = k;
                    res.wr_en = 1'b1;
                    res.dest  = r;
                end
            end
            OP_EQ:
            begin
                res.value = {{(DATA_W-1){1'b0}}, s == k};
                res.wr_en = 1'b1;
                res.dest  = D15_INDEX;
            end
            OP_LT:
            begin
                res.value = {{(DATA_W-1){1'b0}}, $signed(s) < $signed(k)};
                res.wr_en = 1'b1;
                res.dest  = D15_INDEX;
            end
            OP_MOV:
            begin
                res.value = k;
                res.wr_en = 1'b1;
                res.dest  = r;
            end
            OP_MOV_ADDR:
            begin
                res.value   = {{(DATA_W-4){1'b0}}, kraw};
                res.wr_en   = 1'b1;
                res.to_addr = 1'b1;
                res.dest    = r;
            end
            OP_SH:
            begin
                res.value = (cnt >= 0) ? (s << cnt) : (s >> -cnt);
                res.wr_en = 1'b1;
                res.dest  = r;
            end
            OP_SHA:
            begin
                if (cnt == 0)
                begin
                    c_flag    = 1'b0;
                    v_flag    = 1'b0;
                    res.value = s;
                end
                else if (cnt > 0)
                begin
                    n         = cnt;
                    tmax      = MAX_POS >> n;
                    msk       = ((32'd1 << n) - 32'd1) << (DATA_W - n);
                    c_flag    = |(s & msk);
                    v_flag    = ($signed(s) > $signed(tmax)) || ($signed(s) < $signed(~tmax));
                    sv_flag   = sv_flag | v_flag;
                    res.value = s << n;
                end
                else
                begin
                    n         = -cnt;
                    v_flag    = 1'b0;
                    c_flag    = |(s & ((32'd1 << n) - 32'd1));
                    res.value = $signed(s) >>> n;
                end
                av_flag   = res.value[31] ^ res.value[30];
                sav_flag  = sav_flag | av_flag;
                res.wr_en = 1'b1;
                res.dest  = r;
            end
            default:
            begin
            end
        endcase
        if (res.wr_en)
        begin
            if (res.to_addr)
                addr_file[res.dest] = res.value;
            else
                data_file[res.dest] = res.value;
        end
        res.c   = c_flag;
        res.v   = v_flag;
        res.sv  = sv_flag;
        res.av  = av_flag;
        res.sav = sav_flag;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        writeback_t got;
        writeback_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                data_file[i] = '0;
                addr_file[i] = '0;
            end
            c_flag   = 1'b0;
            v_flag   = 1'b0;
            sv_flag  = 1'b0;
            av_flag  = 1'b0;
            sav_flag = 1'b0;
            writeback_q.delete();
            pending <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                writeback_q.push_back(execute_instr(s_axis_tdata[3:0], s_axis_tdata[7:4],
                                                    s_axis_tdata[11:8]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[$bits(writeback_t)-1:0];
                if (writeback_q.size() == 0)
                    report_mismatch("result beat with nothing expected", got.value, '0);
                else
                begin
                    want = writeback_q.pop_front();
                    if (got.wr_en !== want.wr_en)
                        report_mismatch("write_enable", DATA_W'(got.wr_en),
                                        DATA_W'(want.wr_en));
                    if (got.to_addr !== want.to_addr)
                        report_mismatch("dest_is_addr", DATA_W'(got.to_addr),
                                        DATA_W'(want.to_addr));
                    if (got.dest !== want.dest)
                        report_mismatch("dest_index", DATA_W'(got.dest), DATA_W'(want.dest));
                    if (got.value !== want.value)
                        report_mismatch("write_value", got.value, want.value);
                    if (got.c !== want.c)
                        report_mismatch("flag_c", DATA_W'(got.c), DATA_W'(want.c));
                    if (got.v !== want.v)
                        report_mismatch("flag_v", DATA_W'(got.v), DATA_W'(want.v));
                    if (got.sv !== want.sv)
                        report_mismatch("flag_sv", DATA_W'(got.sv), DATA_W'(want.sv));
                    if (got.av !== want.av)
                        report_mismatch("flag_av", DATA_W'(got.av), DATA_W'(want.av));
                    if (got.sav !== want.sav)
                        report_mismatch("flag_sav", DATA_W'(got.sav), DATA_W'(want.sav));
                end
            end
            pending <= writeback_q.size();
        end
    end

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives short-form instructions into the ALU execute unit: a directed pass
// over every op, the constant extremes, both branches of each conditional op,
// overflow and shift edge cases and the unused op codes, then random
// instruction chains under bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sfae_pkg::*;

    localparam int         RANDOM_ITEMS    = 800;
    localparam int         DRAIN_EVERY     = 200;
    localparam int         CYCLE_LIMIT     = 200000;
    localparam int         SETTLE_CYCLES   = 8;
    localparam logic [3:0] OP_FIRST_UNUSED = 4'd14;
    localparam logic [3:0] OP_LAST_UNUSED  = 4'd15;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    int                     mismatches;
    int                     in_flight;
    int                     burst_left = 0;
    int                     cycles = 0;
    op_t                    tail_ops [7] = '{OP_ADD, OP_CADD, OP_CADDN, OP_EQ, OP_LT,
                                             OP_ADD_TO15, OP_SHA};

    short_form_alu_execute_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    alu_result_checker result_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .errors        (mismatches),
        .pending       (in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic issue(input logic [3:0] op, input logic [3:0] r, input logic [3:0] k);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= IN_TDATA_W'($urandom);
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, k, r, op};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (in_flight != 0);
    endtask

    initial
    begin : sink
        int   hold;
        logic level;
        m_axis_tready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    level = 1'b1;
                    hold  = $urandom_range(20, 60);
                end
                1:
                begin
                    level = 1'b0;
                    hold  = $urandom_range(1, 12);
                end
                default:
                begin
                    level = 1'($urandom_range(0, 1));
                    hold  = $urandom_range(1, 4);
                end
            endcase
            m_axis_tready <= level;
            repeat (hold) @(posedge clk);
        end
    end

    initial
    begin : source
        int         sent;
        int         next_drain;
        int         len;
        logic [3:0] r;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        rst_n         = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // drive extremes and overflow around the signed limits
        issue(OP_MOV, 4'd0, 4'd8);
        issue(OP_MOV, 4'd1, 4'd15);
        issue(OP_SH, 4'd1, 4'd15);
        issue(OP_ADD, 4'd1, 4'd1);
        issue(OP_ADD, 4'd1, 4'd15);
        issue(OP_SHA, 4'd1, 4'd0);
        issue(OP_SHA, 4'd1, 4'd7);
        issue(OP_SHA, 4'd0, 4'd8);
        issue(OP_SH, 4'd0, 4'd7);
        issue(OP_ADD_FROM15, 4'd2, 4'd7);
        issue(OP_ADD_TO15, 4'd2, 4'd8);
        // d15 nonzero here, then zero after the third compare
        issue(OP_CADD, 4'd3, 4'd5);
        issue(OP_CADDN, 4'd3, 4'd5);
        issue(OP_CMOV, 4'd4, 4'd9);
        issue(OP_CMOVN, 4'd4, 4'd9);
        issue(OP_EQ, 4'd4, 4'd9);
        issue(OP_LT, 4'd0, 4'd0);
        issue(OP_EQ, 4'd5, 4'd3);
        issue(OP_CADD, 4'd3, 4'd1);
        issue(OP_CADDN, 4'd3, 4'd1);
        issue(OP_CMOV, 4'd6, 4'd2);
        issue(OP_CMOVN, 4'd6, 4'd2);
        issue(OP_ADDR_ADD, 4'd2, 4'd8);
        issue(OP_MOV_ADDR, 4'd15, 4'd15);
        issue(OP_FIRST_UNUSED, 4'd15, 4'd15);
        issue(OP_LAST_UNUSED, 4'd7, 4'd8);
        drain();

        sent       = 0;
        next_drain = DRAIN_EVERY;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                r   = 4'($urandom);
                len = $urandom_range(1, 4);
                issue(OP_MOV, r, 4'($urandom));
                repeat (len)
                    issue($urandom_range(0, 1) ? OP_SH : OP_SHA, r, 4'($urandom));
                issue(tail_ops[$urandom_range(0, 6)], r, 4'($urandom));
                sent += len + 2;
            end
            else
            begin
                if ($urandom_range(0, 19) == 0)
                    issue(4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED)),
                          4'($urandom), 4'($urandom));
                else
                    issue(4'($urandom_range(OP_ADD, OP_SHA)), 4'($urandom), 4'($urandom));
                sent++;
            end
            if (sent >= next_drain)
            begin
                drain();
                next_drain += DRAIN_EVERY;
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && in_flight == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
